FILE: rtl/msbd_pkg.sv
package msbd_pkg;

    // item kinds carried in s_tuser
    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_ENABLE = 2'd1,
        KIND_STOP   = 2'd2
    } kind_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_BLOCK_THRESHOLD = 2'd0,
        CFG_INRUSH_WAIT     = 2'd1,
        CFG_MIN_DUTY        = 2'd2
    } cfg_index_t;

    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int THRESHOLD_W     = 10;
    localparam int INRUSH_W        = 16;
    localparam int DUTY_W          = 8;
    localparam int SAMPLE_FIELD_W  = 10;
    localparam int AVG_W           = 10;
    localparam logic [INRUSH_W-1:0] INRUSH_WAIT_RESET = 16'd400;

    typedef struct packed {
        logic [THRESHOLD_W-1:0] block_threshold;
        logic [INRUSH_W-1:0]    inrush_wait;
        logic [DUTY_W-1:0]      min_duty;
    } cfg_t;

    // motor state after the item, as the result beat needs it
    typedef struct packed {
        logic [DUTY_W-1:0] pwm_duty;
        logic              dir_out;
        logic              brake_on;
        logic              armed;
    } motor_status_t;

endpackage

FILE: rtl/motor_soft_start_block_detect.sv
// Motor soft-start controller with stall detection. Each s_ beat is a tick
// (one current-sense sample), an enable (direction and target duty, clamped to
// [min_duty, MAX_DUTY]) or a stop, chosen by s_tuser; every beat yields exactly
// one m_ beat with the motor state after it. The block takes one beat per
// clock while m_tready stays high and keeps up with back-to-back traffic: an
// input register, a state update stage and a result register form a
// three-stage pipeline, and each stage only holds while the one behind it is
// full and stalled. The running mean is a sum over a shift line of
// SAMPLE_COUNT samples, divided through a constant reciprocal multiply in the
// result stage. Configuration writes have no read-back and are meant for
// idle periods.
module motor_soft_start_block_detect #(
    parameter int SAMPLE_COUNT = 16,
    parameter int MAX_DUTY     = 255,
    parameter int ADC_BITS     = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // config write port, index per the register list
    input  logic                                cfg_wr_en,
    input  logic [msbd_pkg::CFG_INDEX_W-1:0]    cfg_addr,
    input  logic [msbd_pkg::CFG_DATA_W-1:0]     cfg_wdata,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] direction, [8:1] target_duty, [18:9] current_sample, rest zero
    input  logic [23:0]                         s_tdata,
    // [1:0] kind
    input  logic [1:0]                          s_tuser,

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] pwm_duty, [8] dir_out, [9] brake_on, [10] is_blocked,
    // [20:11] avg_current, rest zero
    output logic [23:0]                         m_tdata
);
    import msbd_pkg::*;

    // samples wider than the field are cut to the field
    localparam int SAMPLE_W = (ADC_BITS < SAMPLE_FIELD_W) ? ADC_BITS : SAMPLE_FIELD_W;
    localparam int SUM_W    = SAMPLE_W + $clog2(SAMPLE_COUNT);

    // configuration registers
    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.block_threshold <= '0;
            cfg_reg.inrush_wait     <= INRUSH_WAIT_RESET;
            cfg_reg.min_duty        <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_BLOCK_THRESHOLD: cfg_reg.block_threshold <= cfg_wdata[THRESHOLD_W-1:0];
                CFG_INRUSH_WAIT:     cfg_reg.inrush_wait     <= cfg_wdata[INRUSH_W-1:0];
                CFG_MIN_DUTY:        cfg_reg.min_duty        <= cfg_wdata[DUTY_W-1:0];
                default: begin
                    // writes past the list are dropped
                end
            endcase
        end
    end

    // stage handshakes: each stage takes a beat when empty or draining
    logic a_valid_reg, b_valid_reg, c_valid_reg;
    logic a_ready, b_ready, c_ready;
    logic step;

    assign c_ready  = !c_valid_reg || m_tready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign s_tready = a_ready;
    assign step     = a_valid_reg && b_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= s_tvalid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    // input register
    logic [1:0]                a_kind_reg;
    logic                      a_dir_reg;
    logic [DUTY_W-1:0]         a_target_reg;
    logic [SAMPLE_FIELD_W-1:0] a_sample_reg;

    always_ff @(posedge aclk) begin
        if (a_ready && s_tvalid) begin
            a_kind_reg   <= s_tuser;
            a_dir_reg    <= s_tdata[0];
            a_target_reg <= s_tdata[8:1];
            a_sample_reg <= s_tdata[18:9];
        end
    end

    // state update, committed when the beat moves into stage b
    motor_status_t       status;
    logic [SAMPLE_W-1:0] newest_next;
    logic [SUM_W-1:0]    sum_next;
    logic                blocked;

    msbd_motor #(
        .MAX_DUTY (MAX_DUTY)
    ) u_motor (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .kind        (a_kind_reg),
        .direction   (a_dir_reg),
        .target_duty (a_target_reg),
        .cfg         (cfg_reg),
        .status      (status)
    );

    msbd_window #(
        .SAMPLE_COUNT (SAMPLE_COUNT),
        .SAMPLE_W     (SAMPLE_W),
        .SUM_W        (SUM_W)
    ) u_window (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .kind           (a_kind_reg),
        .current_sample (a_sample_reg),
        .newest_next    (newest_next),
        .sum_next       (sum_next)
    );

    // stall only once inrush is over, and never with a zero threshold
    assign blocked = (cfg_reg.block_threshold != '0) && status.armed &&
                     (THRESHOLD_W'(newest_next) > cfg_reg.block_threshold);

    // stage b: status and raw sum
    logic [DUTY_W-1:0] b_pwm_reg;
    logic              b_dir_reg;
    logic              b_brake_reg;
    logic              b_blocked_reg;
    logic [SUM_W-1:0]  b_sum_reg;

    always_ff @(posedge aclk) begin
        if (step) begin
            b_pwm_reg     <= status.pwm_duty;
            b_dir_reg     <= status.dir_out;
            b_brake_reg   <= status.brake_on;
            b_blocked_reg <= blocked;
            b_sum_reg     <= sum_next;
        end
    end

    // stage c: mean from the sum, result register
    logic [AVG_W-1:0]  avg;
    logic [DUTY_W-1:0] c_pwm_reg;
    logic              c_dir_reg;
    logic              c_brake_reg;
    logic              c_blocked_reg;
    logic [AVG_W-1:0]  c_avg_reg;

    msbd_mean #(
        .SAMPLE_COUNT (SAMPLE_COUNT),
        .SAMPLE_W     (SAMPLE_W),
        .SUM_W        (SUM_W)
    ) u_mean (
        .sum (b_sum_reg),
        .avg (avg)
    );

    always_ff @(posedge aclk) begin
        if (c_ready && b_valid_reg) begin
            c_pwm_reg     <= b_pwm_reg;
            c_dir_reg     <= b_dir_reg;
            c_brake_reg   <= b_brake_reg;
            c_blocked_reg <= b_blocked_reg;
            c_avg_reg     <= avg;
        end
    end

    assign m_tvalid = c_valid_reg;
    assign m_tdata  = {3'b000, c_avg_reg, c_blocked_reg, c_brake_reg, c_dir_reg, c_pwm_reg};

endmodule

FILE: rtl/msbd_motor.sv
module msbd_motor #(
    parameter int MAX_DUTY = 255
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            step,
    input  logic [1:0]                      kind,
    input  logic                            direction,
    input  logic [msbd_pkg::DUTY_W-1:0]     target_duty,
    input  msbd_pkg::cfg_t                  cfg,
    output msbd_pkg::motor_status_t         status
);
    import msbd_pkg::*;

    localparam logic [DUTY_W-1:0] DUTY_CAP =
        DUTY_W'((MAX_DUTY > 255) ? 255 : MAX_DUTY);

    logic                running_reg, running_next;
    logic                rot_dir_reg, rot_dir_next;
    logic [DUTY_W-1:0]   goal_reg, goal_next;
    logic [DUTY_W-1:0]   ramp_reg, ramp_next;
    logic [INRUSH_W-1:0] inrush_reg, inrush_next;
    logic [DUTY_W-1:0]   clamped;

    always_comb begin
        clamped = (target_duty < cfg.min_duty) ? cfg.min_duty : target_duty;
        if (clamped > DUTY_CAP) begin
            clamped = DUTY_CAP;
        end
    end

    always_comb begin
        running_next = running_reg;
        rot_dir_next = rot_dir_reg;
        goal_next    = goal_reg;
        ramp_next    = ramp_reg;
        inrush_next  = inrush_reg;
        case (kind_t'(kind))
            KIND_TICK: begin
                if (running_reg) begin
                    if (ramp_reg < goal_reg) begin
                        ramp_next = ramp_reg + 1'b1;
                    end
                    if (inrush_reg < cfg.inrush_wait) begin
                        inrush_next = inrush_reg + 1'b1;
                    end
                end
            end
            KIND_ENABLE: begin
                // reversing while running restarts the ramp and the inrush wait from zero
                if (running_reg && (rot_dir_reg != direction)) begin
                    ramp_next   = '0;
                    inrush_next = '0;
                end
                rot_dir_next = direction;
                goal_next    = clamped;
                running_next = 1'b1;
            end
            KIND_STOP: begin
                running_next = 1'b0;
                ramp_next    = '0;
                inrush_next  = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            rot_dir_reg <= 1'b0;
            goal_reg    <= '0;
            ramp_reg    <= '0;
            inrush_reg  <= '0;
        end else if (step) begin
            running_reg <= running_next;
            rot_dir_reg <= rot_dir_next;
            goal_reg    <= goal_next;
            ramp_reg    <= ramp_next;
            inrush_reg  <= inrush_next;
        end
    end

    always_comb begin
        status.pwm_duty = running_next ? ramp_next : '0;
        status.dir_out  = rot_dir_next;
        status.brake_on = !running_next;
        status.armed    = (inrush_next >= cfg.inrush_wait);
    end

endmodule

FILE: rtl/msbd_window.sv
module msbd_window #(
    parameter int SAMPLE_COUNT = 16,
    parameter int SAMPLE_W     = 10,
    parameter int SUM_W        = 14
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  step,
    input  logic [1:0]                            kind,
    input  logic [msbd_pkg::SAMPLE_FIELD_W-1:0]   current_sample,
    output logic [SAMPLE_W-1:0]                   newest_next,
    output logic [SUM_W-1:0]                      sum_next
);
    import msbd_pkg::*;

    // shift line: tap 0 newest, last tap oldest
    logic [SAMPLE_W-1:0] taps_reg [SAMPLE_COUNT];
    logic [SAMPLE_W-1:0] newest_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SAMPLE_W-1:0] sample;
    logic                tick;

    assign sample = current_sample[SAMPLE_W-1:0];
    assign tick   = (kind_t'(kind) == KIND_TICK);

    always_comb begin
        if (tick) begin
            newest_next = sample;
            sum_next    = sum_reg - SUM_W'(taps_reg[SAMPLE_COUNT-1]) + SUM_W'(sample);
        end else begin
            newest_next = newest_reg;
            sum_next    = sum_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SAMPLE_COUNT; i++) begin
                taps_reg[i] <= '0;
            end
            newest_reg <= '0;
            sum_reg    <= '0;
        end else if (step && tick) begin
            taps_reg[0] <= sample;
            for (int i = 1; i < SAMPLE_COUNT; i++) begin
                taps_reg[i] <= taps_reg[i-1];
            end
            newest_reg <= newest_next;
            sum_reg    <= sum_next;
        end
    end

endmodule

FILE: rtl/msbd_mean.sv
module msbd_mean #(
    parameter int SAMPLE_COUNT = 16,
    parameter int SAMPLE_W     = 10,
    parameter int SUM_W        = 14
) (
    input  logic [SUM_W-1:0]           sum,
    output logic [msbd_pkg::AVG_W-1:0] avg
);
    import msbd_pkg::*;

    // floor(sum / SAMPLE_COUNT) by reciprocal, exact for every sum below 2**SUM_W
    localparam int SHIFT = SUM_W + $clog2(SAMPLE_COUNT);
    localparam logic [SHIFT-1:0] RECIP =
        SHIFT'(((2 ** SHIFT) + SAMPLE_COUNT - 1) / SAMPLE_COUNT);

    logic [SUM_W+SHIFT-1:0] product;

    assign product = (SUM_W + SHIFT)'(sum) * (SUM_W + SHIFT)'(RECIP);
    assign avg     = AVG_W'(product[SHIFT +: SAMPLE_W]);

endmodule

FILE: rtl/msbd_checker.sv
module msbd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // brake means the motor is stopped, so no duty is driven
    a_brake_no_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9] |-> m_tdata[7:0] == 8'd0)
        else $error("duty driven with brake applied");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // reset leaves the input side free to take a beat
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

endmodule

bind motor_soft_start_block_detect msbd_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
